[rtl/branch_next_pc_unit_defines.svh]
// Assertion macros for the branch next-PC unit checker.
// Depends on nothing; included by the checker file only.
`ifndef BRANCH_NEXT_PC_UNIT_DEFINES_SVH
`define BRANCH_NEXT_PC_UNIT_DEFINES_SVH

// Checked at every rising edge, ignored while reset is high.
`define BNPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define BNPC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/bnpc_pkg.sv]
// Shared types and constants for the branch next-PC unit.
// No dependencies; imported by bnpc_resolve, branch_next_pc_unit and bnpc_checker.
package bnpc_pkg;

  localparam int InBytes  = 21;
  localparam int OutBytes = 9;

  localparam logic [31:0] B_MASK      = 32'hFC00_0000;
  localparam logic [31:0] B_MATCH     = 32'h1400_0000;
  localparam logic [31:0] BR_MASK     = 32'hFFFF_FC1F;
  localparam logic [31:0] BR_MATCH    = 32'hD61F_0000;
  localparam logic [31:0] BCOND_MASK  = 32'hFF00_0010;
  localparam logic [31:0] BCOND_MATCH = 32'h5400_0000;

  localparam logic [3:0] COND_EQ = 4'h0;
  localparam logic [3:0] COND_NE = 4'h1;
  localparam logic [3:0] COND_GE = 4'hA;
  localparam logic [3:0] COND_LT = 4'hB;
  localparam logic [3:0] COND_GT = 4'hC;
  localparam logic [3:0] COND_LE = 4'hD;
  localparam logic [3:0] COND_AL = 4'hE;

  typedef struct packed {
    logic        flag_v;
    logic        flag_z;
    logic        flag_n;
    logic [63:0] reg_value;
    logic [63:0] cur_pc;
    logic [31:0] instr_word;
  } bnpc_in_t;

  typedef struct packed {
    logic        handled;
    logic [63:0] next_pc;
  } bnpc_res_t;

endpackage

[rtl/bnpc_resolve.sv]
// Combinational branch decode, condition check and next-PC adder.
// Depends on bnpc_pkg.
module bnpc_resolve (
  input  bnpc_pkg::bnpc_in_t  item,
  output bnpc_pkg::bnpc_res_t res
);
  import bnpc_pkg::*;

  logic [31:0] w;
  logic        is_b;
  logic        is_br;
  logic        is_bcond;
  logic        take;
  logic        known;
  logic        nv_eq;
  logic [63:0] offset;
  logic [63:0] sum;

  assign w        = item.instr_word;
  assign is_b     = (w & B_MASK) == B_MATCH;
  assign is_br    = (w & BR_MASK) == BR_MATCH;
  assign is_bcond = (w & BCOND_MASK) == BCOND_MATCH;
  assign nv_eq    = item.flag_n == item.flag_v;

  always_comb begin
    take  = 1'b0;
    known = 1'b1;
    unique case (w[3:0])
      COND_EQ: take = item.flag_z;
      COND_NE: take = !item.flag_z;
      COND_GE: take = nv_eq;
      COND_LT: take = !nv_eq;
      COND_GT: take = !item.flag_z && nv_eq;
      COND_LE: take = !(!item.flag_z && nv_eq);
      COND_AL: take = 1'b1;
      default: known = 1'b0;
    endcase
  end

  // Sign taken from the top immediate bit, i.e. bit 27 / bit 20 after scaling
  always_comb begin
    if (is_b) begin
      offset = {{36{w[25]}}, w[25:0], 2'b00};
    end else if (take) begin
      offset = {{43{w[23]}}, w[23:5], 2'b00};
    end else begin
      offset = 64'd4;
    end
  end

  assign sum = item.cur_pc + offset;

  always_comb begin
    priority if (is_b) begin
      res.next_pc = sum;
      res.handled = 1'b1;
    end else if (is_br) begin
      res.next_pc = item.reg_value;
      res.handled = 1'b1;
    end else if (is_bcond && known) begin
      res.next_pc = sum;
      res.handled = 1'b1;
    end else begin
      res.next_pc = item.cur_pc;
      res.handled = 1'b0;
    end
  end

endmodule

[rtl/branch_next_pc_unit.sv]
// Channel   | dir | tdata fields (low bit first)
// s_axis    | in  | instr_word 32, cur_pc 64, reg_value 64, flag_n, flag_z, flag_v, pad 5
// m_axis    | out | next_pc 64, handled 1, pad 7
//
// One beat per cycle sustained while the output is not stalled; beats pass through the input
// register and then the result register, with the single 64-bit adder between the two.
// Reset (rst, synchronous) empties both registers; only the valid bits are reset.
// A stalled output holds; the input stage keeps taking beats while the result
// register can move on or while the input register is empty.
// Top level of the branch next-PC unit; depends on bnpc_pkg and bnpc_resolve.
module branch_next_pc_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // instr_word, cur_pc, reg_value, flag_n, flag_z, flag_v, zero pad
  input  logic [bnpc_pkg::InBytes*8-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // next_pc, handled, zero pad
  output logic [bnpc_pkg::OutBytes*8-1:0] m_axis_tdata
);
  import bnpc_pkg::*;

  localparam int InW  = $bits(bnpc_in_t);
  localparam int OutW = $bits(bnpc_res_t);

  logic      in_valid;
  bnpc_in_t  in_item;
  logic      out_valid;
  bnpc_res_t out_res;
  bnpc_res_t res_next;
  logic      out_adv;
  logic      in_adv;

  assign out_adv       = !out_valid || m_axis_tready;
  assign in_adv        = !in_valid || out_adv;
  assign s_axis_tready = in_adv;

  bnpc_resolve u_resolve (
    .item (in_item),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_adv) begin
        in_valid <= s_axis_tvalid;
      end
      if (out_adv) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && s_axis_tvalid) begin
      in_item <= bnpc_in_t'(s_axis_tdata[InW-1:0]);
    end
    if (out_adv && in_valid) begin
      out_res <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OutBytes*8-OutW){1'b0}}, out_res};

endmodule

[rtl/bnpc_checker.sv]
// Port-level checker for branch_next_pc_unit, with its bind statement.
// Depends on bnpc_pkg and branch_next_pc_unit_defines.svh.
module bnpc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [167:0] s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [71:0]  m_axis_tdata
);
  import bnpc_pkg::*;
`include "branch_next_pc_unit_defines.svh"

  logic        s_beat;
  logic        is_br;
  logic        br_beat;
  logic        m_stall;
  logic        br_out;
  logic [63:0] in_reg;
  logic [63:0] out_pc;

  assign s_beat  = s_axis_tvalid && s_axis_tready;
  assign is_br   = (s_axis_tdata[31:0] & BR_MASK) == BR_MATCH;
  assign br_beat = s_beat && is_br;
  assign m_stall = m_axis_tvalid && !m_axis_tready;
  assign br_out  = m_axis_tvalid && m_axis_tdata[64];
  assign in_reg  = s_axis_tdata[159:96];
  assign out_pc  = m_axis_tdata[63:0];

  `BNPC_ASSERT_RST(a_rst_empty, rst |=> !m_axis_tvalid, "output valid after reset")
  `BNPC_ASSERT(a_hold, m_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled beat changed")
  `BNPC_ASSERT(a_empty_ready, !m_axis_tvalid |-> s_axis_tready, "input blocked when empty")
  `BNPC_ASSERT(a_latency, s_beat ##1 m_axis_tready |=> m_axis_tvalid, "beat lost in pipeline")
  `BNPC_ASSERT(a_br, br_beat ##1 m_axis_tready |=> br_out && out_pc == $past(in_reg, 2), "BR target")

endmodule

bind branch_next_pc_unit bnpc_checker u_bnpc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
